/* hw/rtl/rdc_pkg.sv */
`default_nettype none
package rdc_pkg;

  localparam int MAP_SIDE_DEF = 64;

  localparam int DIST_W   = 20;
  localparam int DIST_MAX = 1048575;
  localparam int POS_W    = 16;
  localparam int VEC_W    = 16;
  localparam int SW_W     = 11;
  localparam int COL_W    = 10;
  localparam int CELL_W   = 6;
  localparam int RAY_W    = 19;
  localparam int COORD_W  = 10;
  localparam int DIVN_W   = 25;
  localparam int DIVD_W   = 19;
  localparam int CFG_IW   = 3;
  localparam int CFG_DW   = 16;

  localparam logic [CFG_IW-1:0] CFG_POS_X   = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_POS_Y   = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_DIR_X   = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_DIR_Y   = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_PLANE_X = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_PLANE_Y = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_WIDTH   = 3'd6;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_CAST  = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE, OP_CLEAR, OP_WRITE, OP_CAST, OP_CAM, OP_RAYX, OP_RAYY,
    OP_DIVX, OP_DX, OP_DIVY, OP_DY, OP_SIDEX, OP_SIDEY, OP_STEP, OP_FINISH
  } op_t;

  typedef struct packed {
    op_t  op;
    logic off;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic div_busy;
    logic start_out;
    logic step_oob;
    logic hit;
    logic iter_last;
    logic out_free;
  } sts_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CAMW, S_CAM, S_RAYX, S_RAYY, S_DIVX, S_DXW, S_DX,
    S_DIVY, S_DYW, S_DY, S_SIDEX, S_SIDEY, S_STEP, S_CHECK, S_DONE
  } state_t;

endpackage
`default_nettype wire

/* hw/rtl/rdc_in_if.sv */
`default_nettype none
interface rdc_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [5:0] cell_x;
  logic [5:0] cell_y;
  logic       wall_bit;
  logic [9:0] column;
  modport source (output valid, mode, cell_x, cell_y, wall_bit, column, input ready);
  modport sink   (input valid, mode, cell_x, cell_y, wall_bit, column, output ready);
endinterface
`default_nettype wire

/* hw/rtl/rdc_out_if.sv */
`default_nettype none
interface rdc_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  out_column;
  logic [5:0]  hit_x;
  logic [5:0]  hit_y;
  logic        hit_side;
  logic [19:0] dist_x_acc;
  logic [19:0] dist_y_acc;
  logic        off_map;
  modport source (output valid, out_column, hit_x, hit_y, hit_side, dist_x_acc,
                  dist_y_acc, off_map, input ready);
  modport sink   (input valid, out_column, hit_x, hit_y, hit_side, dist_x_acc,
                  dist_y_acc, off_map, output ready);
endinterface
`default_nettype wire

/* hw/rtl/rdc_div.sv */
`default_nettype none
module rdc_div #(
  parameter int NW = rdc_pkg::DIVN_W,
  parameter int DW = rdc_pkg::DIVD_W
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               busy,
  output logic [NW-1:0]      quot
);
  localparam int CNT_W = $clog2(NW + 1);

  logic [DW-1:0]    rem_r, rem_nxt;
  logic [NW-1:0]    q_r, q_nxt;
  logic [DW-1:0]    den_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DW:0]      trial;
  logic             ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial    = {rem_r, q_r[NW-1]};
    ge       = trial >= {1'b0, den_r};
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = '0;
      q_nxt    = num;
      cnt_nxt  = CNT_W'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? DW'(trial - {1'b0, den_r}) : DW'(trial);
      q_nxt    = {q_r[NW-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = cnt_r != CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign busy = busy_r;
  assign quot = q_r;
endmodule
`default_nettype wire

/* hw/rtl/rdc_ctrl.sv */
`default_nettype none
module rdc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_mode,
  output logic               in_ready,
  input  wire rdc_pkg::sts_t sts,
  output rdc_pkg::cmd_t      cmd
);
  rdc_pkg::state_t state_r, state_nxt;
  logic            off_r, off_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rdc_pkg::S_CLEAR;
      off_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      off_r   <= off_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    off_nxt   = off_r;
    in_ready  = 1'b0;
    cmd.op    = rdc_pkg::OP_NONE;
    cmd.off   = off_r;
    case (state_r)
      rdc_pkg::S_CLEAR: begin
        cmd.op = rdc_pkg::OP_CLEAR;
        if (sts.clr_done) begin
          state_nxt = rdc_pkg::S_IDLE;
        end
      end
      rdc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode == rdc_pkg::MODE_CAST) begin
            cmd.op    = rdc_pkg::OP_CAST;
            state_nxt = rdc_pkg::S_CAMW;
          end else begin
            cmd.op = rdc_pkg::OP_WRITE;
          end
        end
      end
      rdc_pkg::S_CAMW: if (!sts.div_busy) state_nxt = rdc_pkg::S_CAM;
      rdc_pkg::S_CAM: begin
        cmd.op    = rdc_pkg::OP_CAM;
        state_nxt = rdc_pkg::S_RAYX;
      end
      rdc_pkg::S_RAYX: begin
        cmd.op    = rdc_pkg::OP_RAYX;
        state_nxt = rdc_pkg::S_RAYY;
      end
      rdc_pkg::S_RAYY: begin
        cmd.op    = rdc_pkg::OP_RAYY;
        state_nxt = rdc_pkg::S_DIVX;
      end
      rdc_pkg::S_DIVX: begin
        cmd.op    = rdc_pkg::OP_DIVX;
        state_nxt = rdc_pkg::S_DXW;
      end
      rdc_pkg::S_DXW: if (!sts.div_busy) state_nxt = rdc_pkg::S_DX;
      rdc_pkg::S_DX: begin
        cmd.op    = rdc_pkg::OP_DX;
        state_nxt = rdc_pkg::S_DIVY;
      end
      rdc_pkg::S_DIVY: begin
        cmd.op    = rdc_pkg::OP_DIVY;
        state_nxt = rdc_pkg::S_DYW;
      end
      rdc_pkg::S_DYW: if (!sts.div_busy) state_nxt = rdc_pkg::S_DY;
      rdc_pkg::S_DY: begin
        cmd.op    = rdc_pkg::OP_DY;
        state_nxt = rdc_pkg::S_SIDEX;
      end
      rdc_pkg::S_SIDEX: begin
        cmd.op    = rdc_pkg::OP_SIDEX;
        state_nxt = rdc_pkg::S_SIDEY;
      end
      rdc_pkg::S_SIDEY: begin
        cmd.op = rdc_pkg::OP_SIDEY;
        if (sts.start_out) begin
          off_nxt   = 1'b1;
          state_nxt = rdc_pkg::S_DONE;
        end else begin
          state_nxt = rdc_pkg::S_STEP;
        end
      end
      rdc_pkg::S_STEP: begin
        cmd.op    = rdc_pkg::OP_STEP;
        state_nxt = rdc_pkg::S_CHECK;
      end
      rdc_pkg::S_CHECK: begin
        if (sts.step_oob) begin
          off_nxt   = 1'b1;
          state_nxt = rdc_pkg::S_DONE;
        end else if (sts.hit) begin
          off_nxt   = 1'b0;
          state_nxt = rdc_pkg::S_DONE;
        end else if (sts.iter_last) begin
          off_nxt   = 1'b1;
          state_nxt = rdc_pkg::S_DONE;
        end else begin
          state_nxt = rdc_pkg::S_STEP;
        end
      end
      rdc_pkg::S_DONE: begin
        if (sts.out_free) begin
          cmd.op    = rdc_pkg::OP_FINISH;
          state_nxt = rdc_pkg::S_IDLE;
        end
      end
      default: state_nxt = rdc_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

/* hw/rtl/rdc_datapath.sv */
`default_nettype none
module rdc_datapath #(
  parameter int MAP_SIDE = rdc_pkg::MAP_SIDE_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire rdc_pkg::cmd_t               cmd,
  output rdc_pkg::sts_t                    sts,
  input  wire logic                        cfg_we,
  input  wire logic [rdc_pkg::CFG_IW-1:0]  cfg_index,
  input  wire logic [rdc_pkg::CFG_DW-1:0]  cfg_data,
  input  wire logic [rdc_pkg::CELL_W-1:0]  in_cell_x,
  input  wire logic [rdc_pkg::CELL_W-1:0]  in_cell_y,
  input  wire logic                        in_wall_bit,
  input  wire logic [rdc_pkg::COL_W-1:0]   in_column,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [rdc_pkg::COL_W-1:0]        out_column,
  output logic [rdc_pkg::CELL_W-1:0]       out_hit_x,
  output logic [rdc_pkg::CELL_W-1:0]       out_hit_y,
  output logic                             out_hit_side,
  output logic [rdc_pkg::DIST_W-1:0]       out_dist_x,
  output logic [rdc_pkg::DIST_W-1:0]       out_dist_y,
  output logic                             out_off_map
);
  localparam int IW     = $clog2(MAP_SIDE);
  localparam int AW     = 2 * IW;
  localparam int DEPTH  = 1 << AW;
  localparam int LIMIT  = 4 * MAP_SIDE + 4;
  localparam int ITER_W = $clog2(LIMIT + 1);
  localparam int CW     = rdc_pkg::COORD_W;
  localparam int DW     = rdc_pkg::DIST_W;
  localparam int RW     = rdc_pkg::RAY_W;
  localparam logic signed [CW-1:0] SIDE_S = CW'(MAP_SIDE);
  localparam logic [DW-1:0]        DMAX   = DW'(rdc_pkg::DIST_MAX);

  // configuration registers
  logic [15:0]        pos_x_r, pos_y_r;
  logic signed [15:0] dir_x_r, dir_y_r, plane_x_r, plane_y_r;
  logic [10:0]        width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r   <= 16'd32768;
      pos_y_r   <= 16'd32768;
      dir_x_r   <= -16'sd16384;
      dir_y_r   <= '0;
      plane_x_r <= '0;
      plane_y_r <= 16'sd10813;
      width_r   <= 11'd640;
    end else if (cfg_we) begin
      case (cfg_index)
        rdc_pkg::CFG_POS_X:   pos_x_r   <= cfg_data;
        rdc_pkg::CFG_POS_Y:   pos_y_r   <= cfg_data;
        rdc_pkg::CFG_DIR_X:   dir_x_r   <= cfg_data;
        rdc_pkg::CFG_DIR_Y:   dir_y_r   <= cfg_data;
        rdc_pkg::CFG_PLANE_X: plane_x_r <= cfg_data;
        rdc_pkg::CFG_PLANE_Y: plane_y_r <= cfg_data;
        rdc_pkg::CFG_WIDTH:   width_r   <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // shared divider
  logic                        div_start, div_busy;
  logic [rdc_pkg::DIVN_W-1:0]  div_num, div_q;
  logic [rdc_pkg::DIVD_W-1:0]  div_den;

  rdc_div #(.NW(rdc_pkg::DIVN_W), .DW(rdc_pkg::DIVD_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .quot(div_q)
  );

  logic [rdc_pkg::COL_W-1:0] col_r;
  logic signed [15:0]        cam_r;
  logic signed [RW-1:0]      rx_r, ry_r;
  logic [DW-1:0]             dx_r, dy_r, sx_r, sy_r;
  logic signed [CW-1:0]      mx_r, my_r;
  logic                      side_r, oob_r;
  logic [ITER_W-1:0]         iter_r;
  logic [AW-1:0]             clr_r;

  logic [RW-1:0] magx, magy;
  assign magx = rx_r[RW-1] ? RW'(-rx_r) : RW'(rx_r);
  assign magy = ry_r[RW-1] ? RW'(-ry_r) : RW'(ry_r);

  always_comb begin
    div_start = 1'b0;
    div_num   = {1'b1, {(rdc_pkg::DIVN_W-1){1'b0}}};
    div_den   = rdc_pkg::DIVD_W'(magx);
    case (cmd.op)
      rdc_pkg::OP_CAST: begin
        div_start = 1'b1;
        div_num   = {in_column, 15'd0};
        div_den   = rdc_pkg::DIVD_W'((width_r == '0) ? 11'd1 : width_r);
      end
      rdc_pkg::OP_DIVX: div_start = 1'b1;
      rdc_pkg::OP_DIVY: begin
        div_start = 1'b1;
        div_den   = rdc_pkg::DIVD_W'(magy);
      end
      default: ;
    endcase
  end

  // camera coordinate from quotient, clamped above
  logic signed [15:0] cam_nxt;
  assign cam_nxt = (div_q >= 25'd49151) ? 16'sd32767 : 16'(div_q - 25'd16384);

  // one multiplier for both ray components
  logic signed [15:0] mul_a, mul_d;
  logic signed [31:0] mul_p;
  logic signed [RW-1:0] ray_nxt;
  assign mul_a   = (cmd.op == rdc_pkg::OP_RAYX) ? plane_x_r : plane_y_r;
  assign mul_d   = (cmd.op == rdc_pkg::OP_RAYX) ? dir_x_r : dir_y_r;
  assign mul_p   = mul_a * cam_r;
  assign ray_nxt = RW'(mul_d) + RW'(mul_p >>> 14);

  // step distance from quotient
  logic [DW-1:0] dq_sat;
  assign dq_sat = (div_q > rdc_pkg::DIVN_W'(rdc_pkg::DIST_MAX)) ? DMAX : div_q[DW-1:0];

  // first boundary distance
  logic        neg_sel;
  logic [9:0]  frac_sel;
  logic [10:0] fsel;
  logic [DW-1:0] dsel;
  logic [30:0] side_p;
  logic [DW-1:0] side_sat;
  always_comb begin
    neg_sel  = (cmd.op == rdc_pkg::OP_SIDEX) ? rx_r[RW-1] : ry_r[RW-1];
    frac_sel = (cmd.op == rdc_pkg::OP_SIDEX) ? pos_x_r[9:0] : pos_y_r[9:0];
    dsel     = (cmd.op == rdc_pkg::OP_SIDEX) ? dx_r : dy_r;
    fsel     = neg_sel ? {1'b0, frac_sel} : 11'd1024 - {1'b0, frac_sel};
    side_p   = fsel * dsel;
    side_sat = (side_p[30:10] > 21'(rdc_pkg::DIST_MAX)) ? DMAX : side_p[DW+9:10];
  end

  // one walk step
  logic                 take_x;
  logic [DW:0]          acc_sum;
  logic [DW-1:0]        acc_sat;
  logic signed [CW-1:0] mx_nxt, my_nxt;
  logic                 oob_nxt;
  logic [AW-1:0]        rd_addr;
  always_comb begin
    take_x  = sx_r < sy_r;
    acc_sum = take_x ? {1'b0, sx_r} + {1'b0, dx_r} : {1'b0, sy_r} + {1'b0, dy_r};
    acc_sat = (acc_sum > (DW+1)'(rdc_pkg::DIST_MAX)) ? DMAX : acc_sum[DW-1:0];
    mx_nxt  = mx_r;
    my_nxt  = my_r;
    if (take_x) begin
      mx_nxt = rx_r[RW-1] ? mx_r - 1'b1 : mx_r + 1'b1;
    end else begin
      my_nxt = ry_r[RW-1] ? my_r - 1'b1 : my_r + 1'b1;
    end
    oob_nxt = (mx_nxt < 0) || (my_nxt < 0) || (mx_nxt >= SIDE_S) || (my_nxt >= SIDE_S);
    rd_addr = {my_nxt[IW-1:0], mx_nxt[IW-1:0]};
  end

  // wall map
  logic          mem [0:DEPTH-1];
  logic          rd_r;
  logic          wr_en, wr_data;
  logic [AW-1:0] wr_addr;
  always_comb begin
    wr_en   = 1'b0;
    wr_data = 1'b0;
    wr_addr = clr_r;
    if (cmd.op == rdc_pkg::OP_CLEAR) begin
      wr_en = 1'b1;
    end else if (cmd.op == rdc_pkg::OP_WRITE) begin
      wr_en   = (32'(in_cell_x) < MAP_SIDE) && (32'(in_cell_y) < MAP_SIDE);
      wr_data = in_wall_bit;
      wr_addr = {IW'(in_cell_y), IW'(in_cell_x)};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.op == rdc_pkg::OP_CLEAR) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  // walk and setup registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      rdc_pkg::OP_CAST: begin
        col_r  <= in_column;
        mx_r   <= CW'(pos_x_r[15:10]);
        my_r   <= CW'(pos_y_r[15:10]);
        side_r <= 1'b0;
        oob_r  <= 1'b0;
        iter_r <= '0;
      end
      rdc_pkg::OP_CAM:   cam_r <= cam_nxt;
      rdc_pkg::OP_RAYX:  rx_r  <= ray_nxt;
      rdc_pkg::OP_RAYY:  ry_r  <= ray_nxt;
      rdc_pkg::OP_DX:    dx_r  <= (magx == '0) ? DMAX : dq_sat;
      rdc_pkg::OP_DY:    dy_r  <= (magy == '0) ? DMAX : dq_sat;
      rdc_pkg::OP_SIDEX: sx_r  <= side_sat;
      rdc_pkg::OP_SIDEY: sy_r  <= side_sat;
      rdc_pkg::OP_STEP: begin
        if (take_x) begin
          sx_r <= acc_sat;
        end else begin
          sy_r <= acc_sat;
        end
        mx_r   <= mx_nxt;
        my_r   <= my_nxt;
        side_r <= !take_x;
        oob_r  <= oob_nxt;
        iter_r <= iter_r + 1'b1;
      end
      default: ;
    endcase
  end

  // result register
  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == rdc_pkg::OP_FINISH) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == rdc_pkg::OP_FINISH) begin
      out_column   <= col_r;
      out_hit_x    <= cmd.off ? '0 : mx_r[rdc_pkg::CELL_W-1:0];
      out_hit_y    <= cmd.off ? '0 : my_r[rdc_pkg::CELL_W-1:0];
      out_hit_side <= side_r;
      out_dist_x   <= sx_r;
      out_dist_y   <= sy_r;
      out_off_map  <= cmd.off;
    end
  end

  assign out_valid     = out_valid_r;
  assign sts.clr_done  = clr_r == '1;
  assign sts.div_busy  = div_busy;
  assign sts.start_out = (mx_r >= SIDE_S) || (my_r >= SIDE_S);
  assign sts.step_oob  = oob_r;
  assign sts.hit       = rd_r;
  assign sts.iter_last = iter_r == ITER_W'(LIMIT);
  assign sts.out_free  = !out_valid_r || out_ready;
endmodule
`default_nettype wire

/* hw/rtl/grid_ray_dda_caster.sv */
// Grid ray caster. Load wall cells with mode 0 transfers (no result) and
// cast a ray with a mode 1 transfer; each cast returns one result through a
// held output register, so the next item is taken while a result still
// waits. After reset the wall map is cleared by a pass that writes all
// 2^(2*ceil(log2(MAP_SIDE))) cells (4096 at the default size) with in ready
// low; configuration writes are taken throughout. A cast first runs its
// setup, which uses the bit-per-cycle divider three times (camera coordinate
// and both step distances), then walks the grid with a registered wall map
// read for each step, up to 4*MAP_SIDE+4 steps, and then loads the output
// register once the previous result has been taken.
`default_nettype none
module grid_ray_dda_caster #(
  parameter int MAP_SIDE = rdc_pkg::MAP_SIDE_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  rdc_in_if.sink                          in_ch,
  rdc_out_if.source                       out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [rdc_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [rdc_pkg::CFG_DW-1:0] cfg_data
);
  rdc_pkg::cmd_t cmd;
  rdc_pkg::sts_t sts;

  // sequencer: clear pass, setup steps, walk loop, result handoff
  rdc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_mode(in_ch.mode), .in_ready(in_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  // arithmetic, wall map and result register
  rdc_datapath #(.MAP_SIDE(MAP_SIDE)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_cell_x(in_ch.cell_x), .in_cell_y(in_ch.cell_y),
    .in_wall_bit(in_ch.wall_bit), .in_column(in_ch.column),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_column(out_ch.out_column), .out_hit_x(out_ch.hit_x),
    .out_hit_y(out_ch.hit_y), .out_hit_side(out_ch.hit_side),
    .out_dist_x(out_ch.dist_x_acc), .out_dist_y(out_ch.dist_y_acc),
    .out_off_map(out_ch.off_map)
  );
endmodule
`default_nettype wire

/* hw/rtl/rdc_checker.sv */
`default_nettype none
module rdc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       in_mode,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [5:0] out_hit_x,
  input wire logic [5:0] out_hit_y,
  input wire logic       out_off_map
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit_x) && $stable(out_hit_y))
    else $error("result changed while stalled");

  a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_off_map |-> out_hit_x == 6'd0 && out_hit_y == 6'd0)
    else $error("off-map result carries a cell");

  a_cast_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode |=> !in_ready)
    else $error("input taken during a cast");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready before map clear");
endmodule

bind grid_ray_dda_caster rdc_checker u_rdc_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_mode(in_ch.mode),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_hit_x(out_ch.hit_x), .out_hit_y(out_ch.hit_y), .out_off_map(out_ch.off_map)
);
`default_nettype wire

/* sim/rdc_tb_scoreboard.sv */
`timescale 1ns / 100ps
// Ray result tracker: predicts casts from a local copy of map and registers.
class ray_tracker;
  typedef struct packed {
    logic [9:0]  column;
    logic [5:0]  hx;
    logic [5:0]  hy;
    logic        side;
    logic [19:0] dxa;
    logic [19:0] dya;
    logic        off;
  } ray_hit_t;

  bit        walls [4096];
  logic [15:0] px, py, dirx, diry, plx, ply;
  logic [10:0] width;
  ray_hit_t  pending [$];
  int        errors;

  function new();
    foreach (walls[i]) walls[i] = 0;
    px = 16'd32768; py = 16'd32768;
    dirx = 16'hC000; diry = 16'd0;
    plx = 16'd0; ply = 16'd10813;
    width = 11'd640;
    errors = 0;
  endfunction

  function void set_reg(int idx, logic [15:0] val);
    case (idx)
      0: px = val;
      1: py = val;
      2: dirx = val;
      3: diry = val;
      4: plx = val;
      5: ply = val;
      6: width = val[10:0];
      default: ;
    endcase
  endfunction

  static function longint fdiv14(longint p);
    if (p >= 0) return p / 16384;
    return -((-p + 16383) / 16384);
  endfunction

  static function longint recip(longint r);
    longint m, d;
    m = r < 0 ? -r : r;
    if (m == 0) return 1048575;
    d = (longint'(1) << 24) / m;
    return d > 1048575 ? 1048575 : d;
  endfunction

  function void note_input(logic mode, logic [5:0] cx, logic [5:0] cy, logic wb,
                           logic [9:0] col);
    longint w, cam, rx, ry, dx, dy, sx, sy, mx, my, stx, sty, fx, fy;
    int side, off;
    ray_hit_t e;
    if (mode == rdc_pkg::MODE_WRITE) begin
      walls[{cy, cx}] = wb;
      return;
    end
    w = width == 0 ? 1 : width;
    cam = (2 * longint'(col) * 16384) / w - 16384;
    if (cam > 32767) cam = 32767;
    if (cam < -32768) cam = -32768;
    rx = longint'($signed(dirx)) + fdiv14(longint'($signed(plx)) * cam);
    ry = longint'($signed(diry)) + fdiv14(longint'($signed(ply)) * cam);
    dx = recip(rx);
    dy = recip(ry);
    mx = px >> 10; my = py >> 10;
    fx = px & 1023; fy = py & 1023;
    stx = rx < 0 ? -1 : 1;
    sty = ry < 0 ? -1 : 1;
    sx = ((rx < 0 ? fx : 1024 - fx) * dx) >> 10;
    sy = ((ry < 0 ? fy : 1024 - fy) * dy) >> 10;
    if (sx > 1048575) sx = 1048575;
    if (sy > 1048575) sy = 1048575;
    side = 0; off = 1;
    for (int i = 0; i < 4 * 64 + 4; i++) begin
      if (sx < sy) begin
        sx = sx + dx; if (sx > 1048575) sx = 1048575;
        mx += stx; side = 0;
      end else begin
        sy = sy + dy; if (sy > 1048575) sy = 1048575;
        my += sty; side = 1;
      end
      if (mx < 0 || my < 0 || mx >= 64 || my >= 64) break;
      if (walls[my * 64 + mx]) begin
        off = 0;
        break;
      end
    end
    e.column = col;
    e.hx = off ? 6'd0 : mx[5:0];
    e.hy = off ? 6'd0 : my[5:0];
    e.side = side[0];
    e.dxa = sx[19:0];
    e.dya = sy[19:0];
    e.off = off[0];
    pending.push_back(e);
  endfunction

  function void report(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endfunction

  function void check_result(ray_hit_t got);
    ray_hit_t e;
    if (pending.size() == 0) begin
      report("unexpected result, column", got.column, -1);
      return;
    end
    e = pending.pop_front();
    if (got.column !== e.column) report("out_column", got.column, e.column);
    if (got.hx !== e.hx) report("hit_x", got.hx, e.hx);
    if (got.hy !== e.hy) report("hit_y", got.hy, e.hy);
    if (got.side !== e.side) report("hit_side", got.side, e.side);
    if (got.dxa !== e.dxa) report("dist_x_acc", got.dxa, e.dxa);
    if (got.dya !== e.dya) report("dist_y_acc", got.dya, e.dya);
    if (got.off !== e.off) report("off_map", got.off, e.off);
  endfunction
endclass

/* sim/testbench.sv */
`timescale 1ns / 100ps
module testbench;

  // Worst stall: clear pass, cast setup and up to 260 walk steps, plus gaps.
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int DRAIN_CYCLES   = 1200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [rdc_pkg::CFG_IW-1:0] cfg_index = '0;
  logic [rdc_pkg::CFG_DW-1:0] cfg_data = '0;

  rdc_in_if  in_ch ();
  rdc_out_if out_ch ();

  grid_ray_dda_caster DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  ray_tracker tracker = new();

  int  idle_pct = 32;   // chance (percent) that a side idles in a cycle
  int  quiet_cycles;
  bit  sending = 1'b0;

  initial begin
    in_ch.valid = 1'b0; in_ch.mode = 1'b0; in_ch.cell_x = '0;
    in_ch.cell_y = '0; in_ch.wall_bit = 1'b0; in_ch.column = '0;
    out_ch.ready = 1'b0;
  end

  // Result side: random backpressure, every transfer goes to the checker.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      tracker.check_result({out_ch.out_column, out_ch.hit_x, out_ch.hit_y,
                            out_ch.hit_side, out_ch.dist_x_acc, out_ch.dist_y_acc,
                            out_ch.off_map});
    out_ch.ready <= ($urandom_range(99) >= idle_pct);
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic cfg_write(input logic [rdc_pkg::CFG_IW-1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_reg(idx, val);
  endtask

  // Drive one item; valid stays high until the transfer, then the caller
  // decides whether to drop it, so no double assignment in one step.
  task automatic send_item(input logic mode, input logic [5:0] cx, input logic [5:0] cy,
                           input logic wb, input logic [9:0] col);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1; in_ch.mode <= mode; in_ch.cell_x <= cx;
    in_ch.cell_y <= cy; in_ch.wall_bit <= wb; in_ch.column <= col;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_input(mode, cx, cy, wb, col);
  endtask

  task automatic cast(input logic [9:0] col);
    send_item(rdc_pkg::MODE_CAST, 6'($urandom), 6'($urandom), 1'($urandom), col);
  endtask

  task automatic put_cell(input logic [5:0] cx, input logic [5:0] cy, input logic wb);
    send_item(rdc_pkg::MODE_WRITE, cx, cy, wb, 10'($urandom));
  endtask

  // Block until every cast has returned, then let any trailing walk finish.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_view();
    cfg_write(rdc_pkg::CFG_POS_X, {6'($urandom_range(4, 59)), 10'($urandom)});
    cfg_write(rdc_pkg::CFG_POS_Y, {6'($urandom_range(4, 59)), 10'($urandom)});
    cfg_write(rdc_pkg::CFG_DIR_X, $urandom_range(1) ? 16'($urandom)
                                  : 16'($signed($urandom_range(32767)) - 16384));
    cfg_write(rdc_pkg::CFG_DIR_Y, 16'($urandom));
    cfg_write(rdc_pkg::CFG_PLANE_X, 16'($urandom));
    cfg_write(rdc_pkg::CFG_PLANE_Y, 16'($urandom));
    cfg_write(rdc_pkg::CFG_WIDTH, $urandom_range(9) == 0 ? 16'($urandom_range(2047))
                                                         : 16'($urandom_range(1, 1024)));
  endtask

  initial begin
    int sent;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: default view, empty map (rays run off the grid), border walls.
    cast(10'd0); cast(10'd320); cast(10'd1023);
    put_cell(6'd0, 6'd0, 1'b1); put_cell(6'd63, 6'd63, 1'b1);
    put_cell(6'd20, 6'd32, 1'b1); put_cell(6'd40, 6'd32, 1'b1);
    cast(10'd320); cast(10'd639);
    put_cell(6'd20, 6'd32, 1'b0);
    cast(10'd320);
    settle();
    // Zero ray components, zero width, extreme position and vectors.
    cfg_write(rdc_pkg::CFG_DIR_X, 16'd0); cfg_write(rdc_pkg::CFG_DIR_Y, 16'd0);
    cfg_write(rdc_pkg::CFG_PLANE_X, 16'd0); cfg_write(rdc_pkg::CFG_PLANE_Y, 16'd0);
    cfg_write(rdc_pkg::CFG_WIDTH, 16'd0);
    cast(10'd0); cast(10'd1023);
    settle();
    cfg_write(rdc_pkg::CFG_POS_X, 16'hFFFF); cfg_write(rdc_pkg::CFG_POS_Y, 16'd0);
    cfg_write(rdc_pkg::CFG_DIR_X, 16'h8000); cfg_write(rdc_pkg::CFG_DIR_Y, 16'h7FFF);
    cfg_write(rdc_pkg::CFG_PLANE_X, 16'h7FFF); cfg_write(rdc_pkg::CFG_PLANE_Y, 16'h8000);
    cfg_write(rdc_pkg::CFG_WIDTH, 16'd1);
    cast(10'd0); cast(10'd1); cast(10'd1023);
    settle();
    cfg_write(rdc_pkg::CFG_WIDTH, 16'd2047); cfg_write(rdc_pkg::CFG_POS_X, 16'd0);
    cfg_write(rdc_pkg::CFG_POS_Y, 16'hFFFF);
    cast(10'd512); cast(10'd1023);
    settle();

    // Random: phases of views, each mixing map writes building walls (most items) with casts.
    sent = 0;
    while (sent < 1450) begin
      random_view();
      idle_pct = ($urandom_range(5) == 0) ? 0 : 32;
      for (int k = 0; k < 60; k++) begin
        if ($urandom_range(99) < 55)
          put_cell(6'($urandom), 6'($urandom), $urandom_range(99) < 40);
        else
          cast($urandom_range(9) == 0 ? 10'($urandom) : 10'($urandom_range(1023)));
        sent++;
      end
      settle();
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

/* grid_ray_dda_caster.f */
hw/rtl/rdc_pkg.sv
hw/rtl/rdc_in_if.sv
hw/rtl/rdc_out_if.sv
hw/rtl/rdc_div.sv
hw/rtl/rdc_ctrl.sv
hw/rtl/rdc_datapath.sv
hw/rtl/grid_ray_dda_caster.sv
hw/rtl/rdc_checker.sv
sim/rdc_tb_scoreboard.sv
sim/testbench.sv
